// File: rtl/core/ktc_pkg.sv
package ktc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QBITS     = 64;                  // quotient bits of the divider
    localparam int QCNT_W    = $clog2(QBITS + 1);
    localparam int ROOT_ITER = 32;                  // result bits of the 64-bit root
    localparam int RCNT_W    = $clog2(ROOT_ITER + 1);

    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] CFG_MEAS_NOISE    = 3'd1;
    localparam logic [2:0] CFG_PROC_NOISE    = 3'd2;
    localparam logic [2:0] CFG_SPEED_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_INIT_POS_VAR  = 3'd4;
    localparam logic [2:0] CFG_INIT_VEL_VAR  = 3'd5;
    localparam logic [2:0] CFG_BOUND_SCALE   = 3'd6;

    localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd65536;
    localparam logic [31:0] RST_MEAS_NOISE    = 32'd655360;
    localparam logic [31:0] RST_PROC_NOISE    = 32'd81920;
    localparam logic [31:0] RST_SPEED_LIMIT   = 32'd4587520;
    localparam logic [31:0] RST_INIT_POS_VAR  = 32'd6553600;
    localparam logic [31:0] RST_INIT_VEL_VAR  = 32'd6553600;
    localparam logic [31:0] RST_BOUND_SCALE   = 32'd196608;

    typedef struct packed {
        logic        start;
        logic        neg;     // sign of the numerator
        logic [63:0] mag;     // numerator magnitude
        logic [32:0] den;     // divisor, nonzero
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) return s[32] ? QMIN : QMAX;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) return s[32] ? QMIN : QMAX;
        return s[31:0];
    endfunction

    // sign plus magnitude to saturated Q value
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [65:0] m);
        logic [31:0] lo;
        lo = m[31:0];
        if (!neg) return (m > 66'h7FFF_FFFF) ? QMAX : $signed(lo);
        return (m > 66'h8000_0000) ? QMIN : $signed(-lo);
    endfunction

    // product back to Q format, nearest, ties away from zero
    function automatic logic signed [31:0] round_shift(input logic signed [65:0] p);
        logic [65:0] mag;
        logic [65:0] m;
        mag = p[65] ? 66'(-p) : 66'(p);
        m   = (mag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return sat_mag(p[65], m);
    endfunction

    function automatic logic signed [31:0] clip_reg(input logic [31:0] v);
        return v[31] ? QMAX : $signed(v);
    endfunction

    function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic signed [32:0] zx33(input logic [31:0] u);
        return {1'b0, u};
    endfunction

    function automatic logic signed [32:0] mag33(input logic signed [31:0] x);
        logic signed [32:0] e;
        e = {x[31], x};
        return x[31] ? -e : e;
    endfunction

endpackage

// File: rtl/core/ktc_div.sv
// Restoring divider, one quotient bit per cycle; rounds to nearest and saturates.
module ktc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ktc_pkg::t_div_req    i_req,
    output ktc_pkg::t_unit_sts   o_sts,
    output logic signed [31:0]   o_quo
);

    logic                             r_busy;
    logic                             r_done;
    logic [ktc_pkg::QCNT_W-1:0]       r_cnt;
    logic                             r_neg;
    logic [32:0]                      r_den;
    logic [33:0]                      r_rem;
    logic [63:0]                      r_quo;
    logic [33:0]                      v_shift;
    logic [34:0]                      v_diff;

    always_comb begin
        v_shift = {r_rem[32:0], r_quo[63]};
        v_diff  = {1'b0, v_shift} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ktc_pkg::QCNT_W'(ktc_pkg::QBITS);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.neg;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= i_req.mag + {32'd0, i_req.den[32:1]};   // add half divisor to round
        end else if (r_busy && r_cnt != '0) begin
            if (!v_diff[34]) begin
                r_rem <= v_diff[33:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= v_shift;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
        if (r_busy && r_cnt == '0) begin
            o_quo <= ktc_pkg::sat_mag(r_neg, {2'b00, r_quo});
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// File: rtl/core/ktc_sqrt.sv
// Bit-pair integer square root of a 64-bit value, rounds down.
module ktc_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_val,
    output ktc_pkg::t_unit_sts   o_sts,
    output logic [31:0]          o_root
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] v_trial;

    assign v_trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit >> 2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_r <= '0;
        end else if (r_busy && r_bit != '0) begin
            if (r_v >= v_trial) begin
                r_v <= r_v - v_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
        if (r_busy && r_bit == '0) begin
            o_root <= r_r[31:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

`ifndef SYNTHESIS
    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_bit))
        else $error("root trial bit not one-hot");
`endif

endmodule

// File: rtl/core/kalman_tracker_2d_const_velocity.sv
// Four-state (x, y, vx, vy) constant-velocity Kalman tracker in signed Q16.16 with
// saturating arithmetic. A slave transfer with tuser=1 loads the forecast state from
// tdata and resets the forecast covariance to the configured initial variances; it
// yields no result. A transfer with tuser=0 is a position measurement: the block
// limits the control velocity to the speed limit, corrects the forecast, predicts
// the next forecast, and sends one master transfer with the estimate and
// bound_scale * sqrt(variance) for each state. All work runs on one registered
// 33x33 multiplier, one bit-serial divider and one bit-pair square root unit under
// a step sequencer. A measurement uses up to 12 divides without the speed clamp and
// up to 14 with it, and these dominate its run time. s_axis_tready is low from a
// measurement until its result transfer completes. Configuration is written through
// the plain write port (index per register list); the user must write it only while
// the block is idle, which the block itself does not enforce.
module kalman_tracker_2d_const_velocity (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // config write port
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    // input stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic           s_axis_tuser,   // req_type: 1 init, 0 measurement
    // result stream
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [255:0]   m_axis_tdata    // est_x, est_y, est_vx, est_vy,
                                           // bound_x, bound_y, bound_vx, bound_vy
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,   // divider or root unit busy
        ST_OUT  = 4'b1000
    } t_state;

    // sequencer steps
    typedef enum logic [4:0] {
        SP_H_DIV, SP_H_ADD, SP_N_MX, SP_N_MY, SP_N_LIM, SP_N_CMP,
        SP_C_MUL, SP_C_DIV, SP_C_WR,
        SP_K_S, SP_K_E, SP_K_D1, SP_K_D1W, SP_K_D2, SP_K_D2W, SP_K_D3, SP_K_D3W,
        SP_K_D4, SP_K_D4W, SP_K_D5, SP_K_D5W,
        SP_K_P0, SP_K_P1, SP_K_P2, SP_K_P3, SP_K_P4, SP_K_P5,
        SP_B_SQ, SP_B_MUL, SP_B_WR
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_axis, n_axis;
    logic [1:0] r_bi, n_bi;

    logic [31:0] r_cfg_period, r_cfg_meas, r_cfg_proc, r_cfg_speed;
    logic [31:0] r_cfg_ipos, r_cfg_ivel, r_cfg_scale;

    // forecast state and per-axis covariance block [a b; b c]
    logic signed [31:0] r_pos[2], n_pos[2];
    logic signed [31:0] r_vel[2], n_vel[2];
    logic signed [31:0] r_fa[2], n_fa[2];
    logic signed [31:0] r_fb[2], n_fb[2];
    logic signed [31:0] r_fc[2], n_fc[2];

    // working values
    logic signed [31:0] r_z[2], n_z[2];
    logic signed [31:0] r_u[2], n_u[2];
    logic signed [31:0] r_ep[2], n_ep[2];
    logic signed [31:0] r_ev[2], n_ev[2];
    logic signed [31:0] r_ea[2], n_ea[2];
    logic signed [31:0] r_ec[2], n_ec[2];
    logic [31:0]        r_bnd[4], n_bnd[4];
    logic signed [31:0] r_q, n_q;
    logic [31:0]        r_root, n_root;
    logic [63:0]        r_acc, n_acc;
    logic [32:0]        r_s, n_s;
    logic signed [31:0] r_e, n_e;
    logic signed [31:0] r_a1, n_a1, r_b1, n_b1, r_c1, n_c1;
    logic signed [31:0] r_bb, n_bb, r_tc, n_tc, r_tmp, n_tmp;

    // shared multiplier
    logic signed [32:0] n_ma, n_mb;
    logic signed [65:0] r_prod;

    ktc_pkg::t_div_req  div_req;
    ktc_pkg::t_unit_sts div_sts;
    logic signed [31:0] div_quo;
    logic               sq_start;
    logic [63:0]        sq_val;
    ktc_pkg::t_unit_sts sq_sts;
    logic [31:0]        sq_root;

    ktc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    ktc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_sts   (sq_sts),
        .o_root  (sq_root)
    );

    logic signed [31:0] v_t, v_r, v_q, v_rsp, v_var;
    logic signed [31:0] v_pa, v_pb, v_pc, v_pp, v_pv, v_pz;
    logic signed [33:0] v_s;
    logic [65:0]        v_pm;
    logic [63:0]        v_bp;

    always_comb begin
        v_t   = ktc_pkg::clip_reg(r_cfg_period);
        v_r   = ktc_pkg::clip_reg(r_cfg_meas);
        v_q   = ktc_pkg::clip_reg(r_cfg_proc);
        v_rsp = ktc_pkg::round_shift(r_prod);
        v_pm  = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
        v_pa  = r_fa[r_axis];
        v_pb  = r_fb[r_axis];
        v_pc  = r_fc[r_axis];
        v_pp  = r_pos[r_axis];
        v_pv  = r_vel[r_axis];
        v_pz  = r_z[r_axis];
        v_s   = {{2{v_pa[31]}}, v_pa} + {2'b00, v_r};
        v_bp  = (r_prod[63:0] + (64'd1 << (ktc_pkg::FRAC_BITS - 1))) >> ktc_pkg::FRAC_BITS;
        case (r_bi)
            2'd0:    v_var = r_ea[0];
            2'd1:    v_var = r_ea[1];
            2'd2:    v_var = r_ec[0];
            default: v_var = r_ec[1];
        endcase

        n_state = r_state;
        n_step  = r_step;
        n_axis  = r_axis;
        n_bi    = r_bi;
        n_pos = r_pos; n_vel = r_vel; n_fa = r_fa; n_fb = r_fb; n_fc = r_fc;
        n_z = r_z; n_u = r_u; n_ep = r_ep; n_ev = r_ev; n_ea = r_ea; n_ec = r_ec;
        n_bnd = r_bnd;
        n_q = r_q; n_root = r_root; n_acc = r_acc; n_s = r_s; n_e = r_e;
        n_a1 = r_a1; n_b1 = r_b1; n_c1 = r_c1; n_bb = r_bb; n_tc = r_tc; n_tmp = r_tmp;
        n_ma = '0;
        n_mb = '0;
        div_req  = '0;
        sq_start = 1'b0;
        sq_val   = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        n_pos[0] = s_axis_tdata[31:0];
                        n_pos[1] = s_axis_tdata[63:32];
                        n_vel[0] = s_axis_tdata[95:64];
                        n_vel[1] = s_axis_tdata[127:96];
                        for (int i = 0; i < 2; i++) begin
                            n_fa[i] = ktc_pkg::clip_reg(r_cfg_ipos);
                            n_fb[i] = '0;
                            n_fc[i] = ktc_pkg::clip_reg(r_cfg_ivel);
                        end
                    end else begin
                        n_z[0]  = s_axis_tdata[31:0];
                        n_z[1]  = s_axis_tdata[63:32];
                        n_state = ST_RUN;
                        n_step  = SP_H_DIV;
                        n_axis  = 1'b0;
                    end
                end
            end
            ST_RUN: begin
                case (r_step)
                    // control velocity: pos / (2 dT) + vel
                    SP_H_DIV: begin
                        n_step = SP_H_ADD;
                        if (v_t == '0) begin
                            n_q = (v_pp > 0) ? ktc_pkg::QMAX
                                : (v_pp < 0) ? ktc_pkg::QMIN : '0;
                        end else begin
                            div_req.start = 1'b1;
                            div_req.neg   = v_pp[31];
                            div_req.mag   = {31'd0, ktc_pkg::mag33(v_pp)}
                                            << ktc_pkg::FRAC_BITS;
                            div_req.den   = {v_t, 1'b0};
                            n_state       = ST_WAIT;
                        end
                    end
                    SP_H_ADD: begin
                        n_u[r_axis] = ktc_pkg::sat_add(r_q, v_pv);
                        n_axis      = ~r_axis;
                        n_step      = r_axis ? SP_N_MX : SP_H_DIV;
                    end
                    // speed limit check on the squared norm
                    SP_N_MX: begin
                        n_ma   = ktc_pkg::mag33(r_u[0]);
                        n_mb   = ktc_pkg::mag33(r_u[0]);
                        n_step = SP_N_MY;
                    end
                    SP_N_MY: begin
                        n_acc  = r_prod[63:0];
                        n_ma   = ktc_pkg::mag33(r_u[1]);
                        n_mb   = ktc_pkg::mag33(r_u[1]);
                        n_step = SP_N_LIM;
                    end
                    SP_N_LIM: begin
                        n_acc  = r_acc + r_prod[63:0];
                        n_ma   = ktc_pkg::zx33(r_cfg_speed);
                        n_mb   = ktc_pkg::zx33(r_cfg_speed);
                        n_step = SP_N_CMP;
                    end
                    SP_N_CMP: begin
                        if (r_acc > r_prod[63:0]) begin
                            sq_start = 1'b1;
                            sq_val   = r_acc;
                            n_state  = ST_WAIT;
                            n_step   = SP_C_MUL;
                        end else begin
                            n_step = SP_K_S;
                        end
                    end
                    SP_C_MUL: begin
                        n_ma   = ktc_pkg::sx33(r_u[r_axis]);
                        n_mb   = ktc_pkg::zx33(r_cfg_speed);
                        n_step = SP_C_DIV;
                    end
                    SP_C_DIV: begin
                        div_req.start = 1'b1;
                        div_req.neg   = r_prod[65];
                        div_req.mag   = v_pm[63:0];
                        div_req.den   = {1'b0, r_root};
                        n_state       = ST_WAIT;
                        n_step        = SP_C_WR;
                    end
                    SP_C_WR: begin
                        n_u[r_axis] = r_q;
                        n_axis      = ~r_axis;
                        n_step      = r_axis ? SP_K_S : SP_C_MUL;
                    end
                    // measurement update, one axis at a time
                    SP_K_S: begin
                        n_e = ktc_pkg::sat_sub(v_pz, v_pp);
                        n_s = v_s[32:0];
                        if (v_s > 34'sd0) begin
                            n_step = SP_K_E;
                        end else begin
                            // no gain: estimate is the forecast
                            n_a1         = v_pa;
                            n_b1         = v_pb;
                            n_c1         = v_pc;
                            n_ep[r_axis] = v_pp;
                            n_ev[r_axis] = v_pv;
                            n_step       = SP_K_P0;
                        end
                    end
                    SP_K_E: begin
                        n_ma   = ktc_pkg::sx33(v_pa);
                        n_mb   = ktc_pkg::sx33(r_e);
                        n_step = SP_K_D1;
                    end
                    SP_K_D1, SP_K_D2, SP_K_D3, SP_K_D4, SP_K_D5: begin
                        div_req.start = 1'b1;
                        div_req.neg   = r_prod[65];
                        div_req.mag   = v_pm[63:0];
                        div_req.den   = r_s;
                        n_state       = ST_WAIT;
                        case (r_step)
                            SP_K_D1: n_step = SP_K_D1W;
                            SP_K_D2: n_step = SP_K_D2W;
                            SP_K_D3: n_step = SP_K_D3W;
                            SP_K_D4: n_step = SP_K_D4W;
                            default: n_step = SP_K_D5W;
                        endcase
                    end
                    SP_K_D1W: begin
                        n_ep[r_axis] = ktc_pkg::sat_add(v_pp, r_q);
                        n_ma         = ktc_pkg::sx33(v_pb);
                        n_mb         = ktc_pkg::sx33(r_e);
                        n_step       = SP_K_D2;
                    end
                    SP_K_D2W: begin
                        n_ev[r_axis] = ktc_pkg::sat_add(v_pv, r_q);
                        n_ma         = ktc_pkg::sx33(v_pa);
                        n_mb         = ktc_pkg::sx33(v_r);
                        n_step       = SP_K_D3;
                    end
                    SP_K_D3W: begin
                        n_a1   = r_q;
                        n_ma   = ktc_pkg::sx33(v_pb);
                        n_mb   = ktc_pkg::sx33(v_r);
                        n_step = SP_K_D4;
                    end
                    SP_K_D4W: begin
                        n_b1   = r_q;
                        n_ma   = ktc_pkg::sx33(v_pb);
                        n_mb   = ktc_pkg::sx33(v_pb);
                        n_step = SP_K_D5;
                    end
                    SP_K_D5W: begin
                        n_c1   = ktc_pkg::sat_sub(v_pc, r_q);
                        n_step = SP_K_P0;
                    end
                    // covariance and state prediction
                    SP_K_P0: begin
                        n_ma   = ktc_pkg::sx33(v_t);
                        n_mb   = ktc_pkg::sx33(r_b1);
                        n_step = SP_K_P1;
                    end
                    SP_K_P1: begin
                        n_bb   = v_rsp;
                        n_ma   = ktc_pkg::sx33(v_t);
                        n_mb   = ktc_pkg::sx33(r_c1);
                        n_step = SP_K_P2;
                    end
                    SP_K_P2: begin
                        n_tc   = v_rsp;
                        n_ma   = ktc_pkg::sx33(v_t);
                        n_mb   = ktc_pkg::sx33(v_rsp);
                        n_step = SP_K_P3;
                    end
                    SP_K_P3: begin
                        n_fa[r_axis] = ktc_pkg::sat_add(
                            ktc_pkg::sat_add(r_a1, ktc_pkg::sat_add(r_bb, r_bb)), v_rsp);
                        n_fb[r_axis] = ktc_pkg::sat_add(r_b1, r_tc);
                        n_fc[r_axis] = ktc_pkg::sat_add(r_c1, v_q);
                        n_ea[r_axis] = r_a1;
                        n_ec[r_axis] = r_c1;
                        n_ma         = ktc_pkg::sx33(v_t);
                        n_mb         = ktc_pkg::sx33(r_ev[r_axis]);
                        n_step       = SP_K_P4;
                    end
                    SP_K_P4: begin
                        n_tmp  = ktc_pkg::sat_add(r_ep[r_axis], v_rsp);
                        n_ma   = ktc_pkg::sx33(v_t);
                        n_mb   = ktc_pkg::sx33(r_u[r_axis]);
                        n_step = SP_K_P5;
                    end
                    SP_K_P5: begin
                        n_pos[r_axis] = ktc_pkg::sat_sub(r_tmp, v_rsp);
                        n_vel[r_axis] = r_ev[r_axis];
                        n_axis        = ~r_axis;
                        n_bi          = '0;
                        n_step        = r_axis ? SP_B_SQ : SP_K_S;
                    end
                    // bounds: scale * sqrt(var)
                    SP_B_SQ: begin
                        sq_start = 1'b1;
                        sq_val   = (v_var > 0)
                                 ? ({32'd0, v_var} << ktc_pkg::FRAC_BITS) : '0;
                        n_state  = ST_WAIT;
                        n_step   = SP_B_MUL;
                    end
                    SP_B_MUL: begin
                        n_ma   = ktc_pkg::zx33(r_cfg_scale);
                        n_mb   = ktc_pkg::zx33(r_root);
                        n_step = SP_B_WR;
                    end
                    SP_B_WR: begin
                        n_bnd[r_bi] = (|v_bp[63:32]) ? '1 : v_bp[31:0];
                        if (r_bi == 2'd3) begin
                            n_state = ST_OUT;
                        end else begin
                            n_bi   = r_bi + 1'b1;
                            n_step = SP_B_SQ;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_WAIT: begin
                if (div_sts.done) begin
                    n_q     = div_quo;
                    n_state = ST_RUN;
                end else if (sq_sts.done) begin
                    n_root  = sq_root;
                    n_state = ST_RUN;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= SP_H_DIV;
            r_axis  <= 1'b0;
            r_bi    <= '0;
            for (int i = 0; i < 2; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_fa[i]  <= ktc_pkg::clip_reg(ktc_pkg::RST_INIT_POS_VAR);
                r_fb[i]  <= '0;
                r_fc[i]  <= ktc_pkg::clip_reg(ktc_pkg::RST_INIT_VEL_VAR);
            end
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;
            r_bi    <= n_bi;
            r_pos   <= n_pos;
            r_vel   <= n_vel;
            r_fa    <= n_fa;
            r_fb    <= n_fb;
            r_fc    <= n_fc;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period <= ktc_pkg::RST_SAMPLE_PERIOD;
            r_cfg_meas   <= ktc_pkg::RST_MEAS_NOISE;
            r_cfg_proc   <= ktc_pkg::RST_PROC_NOISE;
            r_cfg_speed  <= ktc_pkg::RST_SPEED_LIMIT;
            r_cfg_ipos   <= ktc_pkg::RST_INIT_POS_VAR;
            r_cfg_ivel   <= ktc_pkg::RST_INIT_VEL_VAR;
            r_cfg_scale  <= ktc_pkg::RST_BOUND_SCALE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ktc_pkg::CFG_SAMPLE_PERIOD: r_cfg_period <= i_cfg_data;
                ktc_pkg::CFG_MEAS_NOISE:    r_cfg_meas   <= i_cfg_data;
                ktc_pkg::CFG_PROC_NOISE:    r_cfg_proc   <= i_cfg_data;
                ktc_pkg::CFG_SPEED_LIMIT:   r_cfg_speed  <= i_cfg_data;
                ktc_pkg::CFG_INIT_POS_VAR:  r_cfg_ipos   <= i_cfg_data;
                ktc_pkg::CFG_INIT_VEL_VAR:  r_cfg_ivel   <= i_cfg_data;
                ktc_pkg::CFG_BOUND_SCALE:   r_cfg_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_z <= n_z; r_u <= n_u; r_ep <= n_ep; r_ev <= n_ev; r_ea <= n_ea; r_ec <= n_ec;
        r_bnd <= n_bnd;
        r_q <= n_q; r_root <= n_root; r_acc <= n_acc; r_s <= n_s; r_e <= n_e;
        r_a1 <= n_a1; r_b1 <= n_b1; r_c1 <= n_c1;
        r_bb <= n_bb; r_tc <= n_tc; r_tmp <= n_tmp;
        r_prod <= n_ma * n_mb;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_bnd[3], r_bnd[2], r_bnd[1], r_bnd[0],
                            r_ev[1], r_ev[0], r_ep[1], r_ep[0]};

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_wait_has_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> (div_sts.busy || div_sts.done ||
                                  sq_sts.busy || sq_sts.done))
        else $error("waiting with no unit at work");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_meas_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (r_state != ST_IDLE))
        else $error("measurement transfer did not start the sequencer");
`endif

endmodule

// File: test/kalman_tracker_2d_const_velocity_checker.sv
module kalman_tracker_2d_const_velocity_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [127:0] i_in_data,
    input  logic         i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [255:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    import ktc_pkg::*;

    logic [31:0] period, rnoise, qnoise, vlimit, pvar0, vvar0, bscale;
    logic signed [31:0] fstate [4];
    logic signed [31:0] fcov [16];
    logic [255:0] est_queue [$];

    function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] signed_mag(input logic neg, input logic [63:0] m);
        logic signed [63:0] v;
        if (m > (64'd1 << 62)) m = 64'd1 << 62;
        v = neg ? -$signed(m) : $signed(m);
        return clamp64(v);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [31:0] qplus(input logic signed [31:0] a, b);
        return clamp64(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] qminus(input logic signed [31:0] a, b);
        return clamp64(64'(a) - 64'(b));
    endfunction

    function automatic logic signed [31:0] qtimes(input logic signed [31:0] a, b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return signed_mag(p < 0, (abs64(p) + 64'd32768) >> 16);
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [63:0] n,
                                                input logic [63:0] d);
        return signed_mag(n < 0, (abs64(n) + d / 2) / d);
    endfunction

    function automatic logic signed [31:0] qscale(input logic signed [31:0] a, b,
                                                  input logic [63:0] d);
        return qdiv(64'(a) * 64'(b), d);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sigma_bound(input logic signed [31:0] var_q);
        logic [63:0] m, p;
        m = var_q > 0 ? 64'(var_q) : 64'd0;
        p = (64'(bscale) * root64(m << 16) + 64'd32768) >> 16;
        return p > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    task automatic load_init_cov();
        foreach (fcov[i]) fcov[i] = 0;
        fcov[0] = clip_reg(pvar0);
        fcov[5] = clip_reg(pvar0);
        fcov[10] = clip_reg(vvar0);
        fcov[15] = clip_reg(vvar0);
    endtask

    // one measurement: clamp the control velocity, correct, predict
    task automatic track_update(input logic [127:0] d);
        logic signed [31:0] t, r, q, e, a, b, c, a1, b1, c1, bb, p, v;
        logic signed [31:0] z [2];
        logic signed [31:0] u [2];
        logic signed [31:0] ep [2];
        logic signed [31:0] ev [2];
        logic signed [31:0] ea [2];
        logic signed [31:0] ec [2];
        logic signed [31:0] ncov [16];
        logic signed [63:0] s;
        logic [63:0] mx, my, n2, nrm;
        t = clip_reg(period);
        r = clip_reg(rnoise);
        q = clip_reg(qnoise);
        z[0] = d[31:0];
        z[1] = d[63:32];
        for (int k = 0; k < 2; k++) begin
            p = fstate[k];
            if (t <= 0) begin
                v = p > 0 ? QMAX : (p < 0 ? QMIN : 32'sd0);
            end else begin
                v = qdiv(64'(p) <<< 16, 64'(t) * 2);
            end
            u[k] = qplus(v, fstate[k + 2]);
        end
        mx = abs64(64'(u[0]));
        my = abs64(64'(u[1]));
        n2 = mx * mx + my * my;
        if (n2 > 64'(vlimit) * 64'(vlimit)) begin
            nrm = root64(n2);
            for (int k = 0; k < 2; k++) u[k] = qdiv(64'(u[k]) * $signed(64'(vlimit)), nrm);
        end
        foreach (ncov[i]) ncov[i] = 0;
        for (int k = 0; k < 2; k++) begin
            a = fcov[k * 5];
            b = fcov[k * 5 + 2];
            c = fcov[k * 5 + 10];
            s = 64'(a) + 64'(r);
            a1 = a; b1 = b; c1 = c;
            ep[k] = fstate[k];
            ev[k] = fstate[k + 2];
            if (s > 0) begin
                e = qminus(z[k], fstate[k]);
                ep[k] = qplus(fstate[k], qscale(a, e, s));
                ev[k] = qplus(fstate[k + 2], qscale(b, e, s));
                a1 = qscale(a, r, s);
                b1 = qscale(b, r, s);
                c1 = qminus(c, qscale(b, b, s));
            end
            ea[k] = a1;
            ec[k] = c1;
            bb = qtimes(t, b1);
            ncov[k * 5] = qplus(qplus(a1, qplus(bb, bb)), qtimes(t, qtimes(t, c1)));
            ncov[k * 5 + 2] = qplus(b1, qtimes(t, c1));
            ncov[k * 5 + 8] = ncov[k * 5 + 2];
            ncov[k * 5 + 10] = qplus(c1, q);
        end
        for (int k = 0; k < 2; k++) begin
            fstate[k] = qminus(qplus(ep[k], qtimes(t, ev[k])), qtimes(t, u[k]));
            fstate[k + 2] = ev[k];
        end
        fcov = ncov;
        est_queue.push_back({sigma_bound(ec[1]), sigma_bound(ec[0]), sigma_bound(ea[1]),
                             sigma_bound(ea[0]), ev[1], ev[0], ep[1], ep[0]});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period <= RST_SAMPLE_PERIOD;
            rnoise <= RST_MEAS_NOISE;
            qnoise <= RST_PROC_NOISE;
            vlimit <= RST_SPEED_LIMIT;
            pvar0 <= RST_INIT_POS_VAR;
            vvar0 <= RST_INIT_VEL_VAR;
            bscale <= RST_BOUND_SCALE;
            foreach (fstate[i]) fstate[i] = 0;
            foreach (fcov[i]) fcov[i] = 0;
            fcov[0] = clip_reg(RST_INIT_POS_VAR);
            fcov[5] = clip_reg(RST_INIT_POS_VAR);
            fcov[10] = clip_reg(RST_INIT_VEL_VAR);
            fcov[15] = clip_reg(RST_INIT_VEL_VAR);
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD: period = i_cfg_data;
                    CFG_MEAS_NOISE:    rnoise = i_cfg_data;
                    CFG_PROC_NOISE:    qnoise = i_cfg_data;
                    CFG_SPEED_LIMIT:   vlimit = i_cfg_data;
                    CFG_INIT_POS_VAR:  pvar0 = i_cfg_data;
                    CFG_INIT_VEL_VAR:  vvar0 = i_cfg_data;
                    CFG_BOUND_SCALE:   bscale = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (est_queue.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    logic [255:0] want;
                    want = est_queue.pop_front();
                    for (int f = 0; f < 8; f++) begin
                        if (want[f * 32 +: 32] !== i_out_data[f * 32 +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     want[f * 32 +: 32], i_out_data[f * 32 +: 32]);
                            o_fail_count = o_fail_count + 1;
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user) begin
                    fstate[0] = i_in_data[31:0];
                    fstate[1] = i_in_data[63:32];
                    fstate[2] = i_in_data[95:64];
                    fstate[3] = i_in_data[127:96];
                    load_init_cov();
                end else begin
                    track_update(i_in_data);
                end
            end
        end
        o_pending = est_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule

// File: test/kalman_tracker_2d_const_velocity_tb.sv
module kalman_tracker_2d_const_velocity_tb;
    import ktc_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_index = CFG_SAMPLE_PERIOD;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // pos_x, pos_y, vel_x, vel_y
    logic         s_axis_tuser = 1'b0; // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;        // est_x..est_vy, bound_x..bound_vy

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    bit  calm_tail = 0;        // no idling in the last part
    bit  long_hold = 0;        // receiver stall request
    localparam int CYCLE_LIMIT = 3_000_000;

    always #4 i_clk = ~i_clk;

    kalman_tracker_2d_const_velocity i_dut (.*);

    kalman_tracker_2d_const_velocity_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                long_hold = 0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // one transfer on the input stream, with an occasional random gap before it
    task automatic send_item(input logic kind, input logic [127:0] d);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
        endcase
    endfunction

    function automatic logic [127:0] rand_meas();
        return {64'($urandom()), rand_q(), rand_q()};
    endfunction

    // a track: init, then a run of noisy measurements near a line, with the odd random one
    task automatic run_track(input int len);
        logic signed [31:0] x, y, vx, vy;
        x = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        y = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        vx = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        vy = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        send_item(1'b1, {vy, vx, y, x});
        for (int i = 0; i < len; i++) begin
            x = x + vx + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
            y = y + vy + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
            if ($urandom_range(0, 15) == 0) send_item(1'b0, rand_meas());
            else send_item(1'b0, {64'($urandom()), y, x});
        end
    endtask

    initial begin
        int sent;
        logic [31:0] ext [2];
        ext[0] = 32'h0000_0001;
        ext[1] = 32'hFFFF_FFFF;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both request kinds, clamp, zero period
        send_item(1'b0, '0);
        send_item(1'b1, {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        send_item(1'b0, {64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_item(1'b0, {64'h0, 32'h7FFF_FFFF, 32'h8000_0000});
        send_item(1'b1, {32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001});
        send_item(1'b0, {64'h0, 32'hFFFF_FFFF, 32'h0000_0001});
        send_item(1'b1, {32'h0050_0000, 32'hFFB0_0000, 32'h0100_0000, 32'hFF00_0000});
        send_item(1'b0, {64'h0, 32'h0100_0000, 32'hFF00_0000});
        send_item(1'b0, {64'h0, 32'h0110_0000, 32'hFEF0_0000});
        drain();
        // zero period, zero speed limit, maximum bound scale, large noise
        write_reg(CFG_SAMPLE_PERIOD, 32'd0);
        write_reg(CFG_SPEED_LIMIT, 32'd0);
        write_reg(CFG_BOUND_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_PROC_NOISE, 32'hFFFF_FFFF);
        send_item(1'b1, {32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000});
        send_item(1'b0, {64'h0, 32'h0002_0000, 32'h0003_0000});
        send_item(1'b0, {64'h0, 32'h8000_0000, 32'h7FFF_FFFF});
        drain();
        // negative forecast variance via extreme registers
        write_reg(CFG_INIT_POS_VAR, 32'hFFFF_FFFF);
        write_reg(CFG_INIT_VEL_VAR, 32'hFFFF_FFFF);
        write_reg(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
        write_reg(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_BOUND_SCALE, 32'd0);
        send_item(1'b1, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0});
        send_item(1'b0, {64'h0, 32'h0, 32'h0});
        send_item(1'b0, {64'h0, 32'h7FFF_FFFF, 32'h8000_0000});
        send_item(1'b0, {64'h0, 32'h1234_5678, 32'h8765_4321});
        drain();
        write_reg(CFG_INIT_POS_VAR, ext[0]);
        write_reg(CFG_INIT_VEL_VAR, ext[0]);
        write_reg(CFG_MEAS_NOISE, ext[0]);
        write_reg(CFG_PROC_NOISE, 32'd0);
        write_reg(CFG_SAMPLE_PERIOD, ext[0]);
        write_reg(CFG_SPEED_LIMIT, ext[1]);
        write_reg(CFG_BOUND_SCALE, RST_BOUND_SCALE);
        send_item(1'b1, {32'h0, 32'h0, 32'h0, 32'h0});
        send_item(1'b0, {64'h0, 32'h0001_0000, 32'hFFFF_0000});
        send_item(1'b0, {64'h0, 32'h0002_0000, 32'hFFFE_0000});
        drain();

        // random phases, each with its own settings
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) calm_tail = 1;
            write_reg(CFG_SAMPLE_PERIOD, ph == 1 ? $urandom() : $urandom_range(1 << 12, 4 << 16));
            write_reg(CFG_MEAS_NOISE, ph == 2 ? $urandom() : $urandom_range(1 << 14, 40 << 16));
            write_reg(CFG_PROC_NOISE, ph == 3 ? $urandom() : $urandom_range(0, 4 << 16));
            write_reg(CFG_SPEED_LIMIT, ph == 4 ? $urandom() : $urandom_range(0, 100 << 16));
            write_reg(CFG_INIT_POS_VAR, $urandom_range(1, 400 << 16));
            write_reg(CFG_INIT_VEL_VAR, $urandom_range(1, 400 << 16));
            write_reg(CFG_BOUND_SCALE, ph == 1 ? $urandom() : $urandom_range(0, 6 << 16));
            if (ph == 2) long_hold = 1;   // block stalls its input behind the held result
            for (int n = 0; n < 170; ) begin
                int len;
                len = $urandom_range(3, 30);
                if ($urandom_range(0, 7) == 0) begin
                    send_item($urandom_range(0, 1), {$urandom(), $urandom(), $urandom(), $urandom()});
                    n++;
                end else begin
                    run_track(len);
                    n += len + 1;
                end
            end
            drain();   // sender pauses until every result is in
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: kalman_tracker_2d_const_velocity.f
rtl/core/ktc_pkg.sv
rtl/core/ktc_div.sv
rtl/core/ktc_sqrt.sv
rtl/core/kalman_tracker_2d_const_velocity.sv
test/kalman_tracker_2d_const_velocity_checker.sv
test/kalman_tracker_2d_const_velocity_tb.sv
